// ----- hw/rtl/gda_pkg.sv -----
// ----------------------------------------------------------------------------
// Gregorian date advance package
// Payload types, command and status groups, calendar constants and helpers
// shared by the date advance block.
// ----------------------------------------------------------------------------
package gda_pkg;

   localparam int YEAR_FIELD_BITS = 16;
   localparam int DAYS_FIELD_BITS = 12;
   localparam int CONV_BITS       = 17;
   localparam int CONV_STEPS      = 8;
   localparam int CONV_IDX_BITS   = 3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_WRAPPED = 2'd2;

   localparam logic [0:0] OP_LOAD = 1'b0;
   localparam logic [0:0] OP_ADD  = 1'b1;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_JUN = 4'd6;
   localparam logic [3:0] MONTH_SEP = 4'd9;
   localparam logic [3:0] MONTH_NOV = 4'd11;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   localparam logic [4:0] DAY_FIRST   = 5'd1;
   localparam logic [4:0] DAYS_LEAP   = 5'd29;
   localparam logic [4:0] DAYS_COMMON = 5'd28;
   localparam logic [4:0] DAYS_SHORT  = 5'd30;
   localparam logic [4:0] DAYS_LONG   = 5'd31;

   localparam int         LEAP_CYCLE    = 400;
   localparam logic [8:0] CENTURY_ONE   = 9'd100;
   localparam logic [8:0] CENTURY_TWO   = 9'd200;
   localparam logic [8:0] CENTURY_THREE = 9'd300;
   localparam logic [6:0] REM100_LAST   = 7'd99;

   typedef logic [CONV_BITS-1:0] conv_type;

   typedef struct packed {
      logic [0:0]                 operation;
      logic [YEAR_FIELD_BITS-1:0] load_year;
      logic [3:0]                 load_month;
      logic [4:0]                 load_day;
      logic [DAYS_FIELD_BITS-1:0] add_days;
   } req_payload_type;

   typedef struct packed {
      logic [YEAR_FIELD_BITS-1:0] year_out;
      logic [3:0]                 month_out;
      logic [4:0]                 day_out;
      logic [1:0]                 status;
   } rsp_payload_type;

   typedef struct packed {
      logic capture;
      logic conv_step;
      logic load_check;
      logic add_step;
   } cmd_type;

   typedef struct packed {
      logic conv_last;
      logic days_zero;
   } sts_type;

   // Leap rule on the year modulo 400, split into centuries and remainder.
   function automatic logic is_leap(input logic [6:0] rem100, input logic [1:0] cent);
      is_leap = ((rem100[1:0] == 2'd0) && (rem100 != 7'd0)) ||
                ((rem100 == 7'd0) && (cent == 2'd0));
   endfunction

   function automatic logic [4:0] month_length(input logic leap, input logic [3:0] month);
      unique case (month)
         MONTH_FEB: begin
            month_length = leap ? DAYS_LEAP : DAYS_COMMON;
         end
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: begin
            month_length = DAYS_SHORT;
         end
         default: begin
            month_length = DAYS_LONG;
         end
      endcase
   endfunction

endpackage

// ----- hw/rtl/gda_req_if.sv -----
// ----------------------------------------------------------------------------
// Date advance request channel
// Valid/ready channel carrying load and add items into the block.
// ----------------------------------------------------------------------------
interface gda_req_if;
   logic                     valid;
   logic                     ready;
   gda_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/gda_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Date advance response channel
// Valid/ready channel carrying the stored date and status after each item.
// ----------------------------------------------------------------------------
interface gda_rsp_if;
   logic                     valid;
   logic                     ready;
   gda_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/gda_datapath.sv -----
// ----------------------------------------------------------------------------
// Date advance datapath
// Stored date, year modulo 400 tracking, load check and month stepping.
// ----------------------------------------------------------------------------
module gda_datapath #(
   parameter int YEAR_BITS = 16,
   parameter int DAYS_BITS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  gda_pkg::cmd_type         cmd,
   output gda_pkg::sts_type         sts,
   input  gda_pkg::req_payload_type req_payload,
   output gda_pkg::rsp_payload_type rsp_payload
);

   localparam int YEXT = YEAR_BITS + gda_pkg::YEAR_FIELD_BITS;
   localparam int DEXT = DAYS_BITS + gda_pkg::DAYS_FIELD_BITS;
   localparam int CEXT = DAYS_BITS + 6;

   logic [YEAR_BITS-1:0]              year_ff, year_in;
   logic [3:0]                        month_ff, month_in;
   logic [4:0]                        day_ff, day_in;
   logic [6:0]                        rem100_ff, rem100_in;
   logic [1:0]                        cent_ff, cent_in;
   logic [DAYS_BITS-1:0]              days_ff, days_in;
   logic [1:0]                        status_ff, status_in;
   gda_pkg::req_payload_type          item_ff, item_in;
   gda_pkg::conv_type                 conv_ff, conv_in;
   logic [gda_pkg::CONV_IDX_BITS-1:0] conv_idx_ff, conv_idx_in;

   logic [YEXT-1:0]   load_year_ext;
   logic [YEXT-1:0]   year_out_ext;
   logic [DEXT-1:0]   add_days_ext;
   gda_pkg::conv_type conv_sub;
   logic [8:0]        rem400;
   logic [6:0]        load_rem100;
   logic [1:0]        load_cent;
   logic              load_leap;
   logic              load_ok;
   logic              leap_now;
   logic [4:0]        dim;
   logic [5:0]        room;
   logic [CEXT-1:0]   days_cmp;
   logic [CEXT-1:0]   room_cmp;
   logic [CEXT-1:0]   days_left;
   logic              roll;

   assign load_year_ext = {{YEAR_BITS{1'b0}}, item_ff.load_year};
   assign year_out_ext  = {{gda_pkg::YEAR_FIELD_BITS{1'b0}}, year_ff};
   assign add_days_ext  = {{DAYS_BITS{1'b0}}, req_payload.add_days};

   assign conv_sub = gda_pkg::conv_type'(gda_pkg::LEAP_CYCLE) << conv_idx_ff;
   assign rem400   = conv_ff[8:0];

   always_comb begin
      priority if (rem400 >= gda_pkg::CENTURY_THREE) begin
         load_cent   = 2'd3;
         load_rem100 = 7'(rem400 - gda_pkg::CENTURY_THREE);
      end else if (rem400 >= gda_pkg::CENTURY_TWO) begin
         load_cent   = 2'd2;
         load_rem100 = 7'(rem400 - gda_pkg::CENTURY_TWO);
      end else if (rem400 >= gda_pkg::CENTURY_ONE) begin
         load_cent   = 2'd1;
         load_rem100 = 7'(rem400 - gda_pkg::CENTURY_ONE);
      end else begin
         load_cent   = 2'd0;
         load_rem100 = rem400[6:0];
      end
   end

   assign load_leap = gda_pkg::is_leap(load_rem100, load_cent);
   assign load_ok   = (load_year_ext[YEXT-1:YEAR_BITS] == '0) &&
                      (item_ff.load_month >= gda_pkg::MONTH_JAN) &&
                      (item_ff.load_month <= gda_pkg::MONTH_DEC) &&
                      (item_ff.load_day >= gda_pkg::DAY_FIRST) &&
                      (item_ff.load_day <=
                       gda_pkg::month_length(load_leap, item_ff.load_month));

   assign leap_now  = gda_pkg::is_leap(rem100_ff, cent_ff);
   assign dim       = gda_pkg::month_length(leap_now, month_ff);
   assign room      = {1'b0, dim} - {1'b0, day_ff} + 6'd1;
   assign days_cmp  = {6'b0, days_ff};
   assign room_cmp  = {{DAYS_BITS{1'b0}}, room};
   assign roll      = days_cmp >= room_cmp;
   assign days_left = days_cmp - room_cmp;

   always_comb begin
      year_in     = year_ff;
      month_in    = month_ff;
      day_in      = day_ff;
      rem100_in   = rem100_ff;
      cent_in     = cent_ff;
      days_in     = days_ff;
      status_in   = status_ff;
      item_in     = item_ff;
      conv_in     = conv_ff;
      conv_idx_in = conv_idx_ff;

      if (cmd.capture) begin
         item_in     = req_payload;
         conv_in     = {1'b0, req_payload.load_year};
         conv_idx_in = gda_pkg::CONV_IDX_BITS'(gda_pkg::CONV_STEPS - 1);
         days_in     = add_days_ext[DAYS_BITS-1:0];
         status_in   = gda_pkg::STATUS_OK;
      end

      if (cmd.conv_step) begin
         if (conv_ff >= conv_sub) begin
            conv_in = conv_ff - conv_sub;
         end
         conv_idx_in = conv_idx_ff - 1'b1;
      end

      if (cmd.load_check) begin
         if (load_ok) begin
            year_in   = load_year_ext[YEAR_BITS-1:0];
            month_in  = item_ff.load_month;
            day_in    = item_ff.load_day;
            rem100_in = load_rem100;
            cent_in   = load_cent;
         end else begin
            status_in = gda_pkg::STATUS_INVALID;
         end
      end

      if (cmd.add_step) begin
         if (roll) begin
            days_in = days_left[DAYS_BITS-1:0];
            day_in  = gda_pkg::DAY_FIRST;
            if (month_ff == gda_pkg::MONTH_DEC) begin
               month_in = gda_pkg::MONTH_JAN;
               if (&year_ff) begin
                  year_in   = '0;
                  rem100_in = 7'd0;
                  cent_in   = 2'd0;
                  status_in = gda_pkg::STATUS_WRAPPED;
               end else begin
                  year_in = year_ff + 1'b1;
                  if (rem100_ff == gda_pkg::REM100_LAST) begin
                     rem100_in = 7'd0;
                     cent_in   = cent_ff + 2'd1;
                  end else begin
                     rem100_in = rem100_ff + 7'd1;
                  end
               end
            end else begin
               month_in = month_ff + 4'd1;
            end
         end else begin
            days_in = '0;
            day_in  = day_ff + days_cmp[4:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff   <= '0;
         month_ff  <= gda_pkg::MONTH_JAN;
         day_ff    <= gda_pkg::DAY_FIRST;
         rem100_ff <= 7'd0;
         cent_ff   <= 2'd0;
      end else begin
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         rem100_ff <= rem100_in;
         cent_ff   <= cent_in;
      end
   end

   always_ff @(posedge clock) begin
      days_ff     <= days_in;
      status_ff   <= status_in;
      item_ff     <= item_in;
      conv_ff     <= conv_in;
      conv_idx_ff <= conv_idx_in;
   end

   assign sts.conv_last = (conv_idx_ff == '0);
   assign sts.days_zero = (days_ff == '0);

   assign rsp_payload.year_out  = year_out_ext[gda_pkg::YEAR_FIELD_BITS-1:0];
   assign rsp_payload.month_out = month_ff;
   assign rsp_payload.day_out   = day_ff;
   assign rsp_payload.status    = status_ff;

`ifndef SYNTH
   a_remainder_below_cycle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_check |-> (conv_ff < gda_pkg::conv_type'(gda_pkg::LEAP_CYCLE)))
      else $error("Year remainder not reduced below one leap cycle.");

   a_date_in_range: assert property (@(posedge clock) disable iff (reset)
      (month_ff >= gda_pkg::MONTH_JAN) && (month_ff <= gda_pkg::MONTH_DEC) &&
      (day_ff >= gda_pkg::DAY_FIRST) && (day_ff <= dim))
      else $error("Stored date is not a calendar date.");

   a_step_needs_days: assert property (@(posedge clock) disable iff (reset)
      cmd.add_step |-> (days_ff != '0))
      else $error("Month step issued with no days left.");

   a_rem100_tracks: assert property (@(posedge clock) disable iff (reset)
      rem100_ff <= gda_pkg::REM100_LAST)
      else $error("Year remainder modulo 100 out of range.");
`endif

endmodule

// ----- hw/rtl/gda_controller.sv -----
// ----------------------------------------------------------------------------
// Date advance controller
// Sequences load checks and month-by-month adds and runs both handshakes.
// ----------------------------------------------------------------------------
module gda_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [0:0]       req_operation,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gda_pkg::cmd_type cmd,
   input  gda_pkg::sts_type sts
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CONV  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_ADD   = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.capture    = req_valid && req_ready;
      cmd.conv_step  = (state_ff == S_CONV);
      cmd.load_check = (state_ff == S_CHECK);
      cmd.add_step   = (state_ff == S_ADD) && !sts.days_zero;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req_operation == gda_pkg::OP_ADD) ? S_ADD : S_CONV;
            end
         end
         S_CONV: begin
            if (sts.conv_last) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = S_RESP;
         end
         S_ADD: begin
            if (sts.days_zero) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_one_side_busy: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("Request and response sides open at the same time.");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.conv_step, cmd.load_check, cmd.add_step}))
      else $error("More than one datapath command in a cycle.");

   a_transfer_starts_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> ((state_ff == S_CONV) || (state_ff == S_ADD)))
      else $error("Accepted request did not start a load or an add.");
`endif

endmodule

// ----- hw/rtl/gregorian_date_advance.sv -----
// ----------------------------------------------------------------------------
// Gregorian date advance
// Holds a Gregorian date; load items replace it after a validity check and
// add items advance it by a day count, one month per cycle.
// ----------------------------------------------------------------------------
//   Channel   Direction   Carries
//   req_bus   in          operation, load_year/month/day, add_days
//   rsp_bus   out         year_out, month_out, day_out, status
//
// A load finds the year modulo 400 by a restoring reduction, one compare and
// subtract per cycle, then checks the date in the check state.
// An add makes one step per month boundary crossed or final partial step.
// Reset restores 0000-01-01. One item is in flight at a time; the response
// holds while rsp_bus.ready is low and no new request is taken meanwhile.
// ----------------------------------------------------------------------------
module gregorian_date_advance #(
   parameter int YEAR_BITS = 16,
   parameter int DAYS_BITS = 12
) (
   input logic       clock,
   input logic       reset,
   gda_req_if.sink   req_bus,
   gda_rsp_if.source rsp_bus
);

   gda_pkg::cmd_type cmd;
   gda_pkg::sts_type sts;

   gda_controller u_controller (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_operation (req_bus.payload.operation),
      .req_ready     (req_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .cmd           (cmd),
      .sts           (sts)
   );

   gda_datapath #(
      .YEAR_BITS (YEAR_BITS),
      .DAYS_BITS (DAYS_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_bus.payload),
      .rsp_payload (rsp_bus.payload)
   );

endmodule

// ----- verif/gregorian_date_advance_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date advance testbench
// Drives load and add transfers into the date block with random idle bursts
// on both channels. A calendar predictor in the scoreboard tracks the stored
// date and checks each response field by field.
// ----------------------------------------------------------------------------
module gregorian_date_advance_tb;

   localparam int unsigned YEAR_MAX     = (1 << gda_pkg::YEAR_FIELD_BITS) - 1;
   localparam int unsigned RANDOM_ITEMS = 1925;
   localparam int unsigned CALM_ITEMS   = 150;
   localparam int unsigned SETTLE_TICKS = 200;
   localparam longint     RUN_LIMIT_NS = 20_000_000;

   class date_scoreboard;
      gda_pkg::rsp_payload_type   expected_q[$];
      int unsigned                cur_year;
      int unsigned                cur_month;
      int unsigned                cur_day;
      int unsigned                failures;
      int unsigned                checked;
      int unsigned                loads;
      int unsigned                rejects;
      int unsigned                adds;
      int unsigned                wraps;

      function new();
         cur_year  = 0;
         cur_month = gda_pkg::MONTH_JAN;
         cur_day   = gda_pkg::DAY_FIRST;
      endfunction

      static function int unsigned days_in_month(int unsigned y, int unsigned m);
         bit leap;
         leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
         if (m == gda_pkg::MONTH_FEB) begin
            return leap ? gda_pkg::DAYS_LEAP : gda_pkg::DAYS_COMMON;
         end
         if (m == gda_pkg::MONTH_APR || m == gda_pkg::MONTH_JUN ||
             m == gda_pkg::MONTH_SEP || m == gda_pkg::MONTH_NOV) begin
            return gda_pkg::DAYS_SHORT;
         end
         return gda_pkg::DAYS_LONG;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void note_request(gda_pkg::req_payload_type item);
         gda_pkg::rsp_payload_type want;
         int unsigned              y, m, d, left, dim, room, stride;
         logic [1:0]               st;
         st = gda_pkg::STATUS_OK;
         if (item.operation == gda_pkg::OP_LOAD) begin
            loads++;
            if (item.load_month >= gda_pkg::MONTH_JAN &&
                item.load_month <= gda_pkg::MONTH_DEC &&
                item.load_day >= gda_pkg::DAY_FIRST &&
                item.load_day <= days_in_month(item.load_year, item.load_month)) begin
               cur_year  = item.load_year;
               cur_month = item.load_month;
               cur_day   = item.load_day;
            end else begin
               st = gda_pkg::STATUS_INVALID;
               rejects++;
            end
         end else begin
            adds++;
            y    = cur_year;
            m    = cur_month;
            d    = cur_day;
            left = item.add_days;
            while (left > 0) begin
               dim    = days_in_month(y, m);
               room   = dim - d + 1;
               stride = (left < room) ? left : room;
               if (d + stride > dim) begin
                  d = gda_pkg::DAY_FIRST;
                  if (m == gda_pkg::MONTH_DEC) begin
                     m = gda_pkg::MONTH_JAN;
                     if (y == YEAR_MAX) begin
                        y  = 0;
                        st = gda_pkg::STATUS_WRAPPED;
                     end else begin
                        y++;
                     end
                  end else begin
                     m++;
                  end
               end else begin
                  d += stride;
               end
               left -= stride;
            end
            cur_year  = y;
            cur_month = m;
            cur_day   = d;
            if (st == gda_pkg::STATUS_WRAPPED) begin
               wraps++;
            end
         end
         want.year_out  = gda_pkg::YEAR_FIELD_BITS'(cur_year);
         want.month_out = 4'(cur_month);
         want.day_out   = 5'(cur_day);
         want.status    = st;
         expected_q.push_back(want);
      endfunction

      function void check_response(gda_pkg::rsp_payload_type got);
         gda_pkg::rsp_payload_type want;
         if (expected_q.size() == 0) begin
            $error("Response with no request outstanding: %0d-%0d-%0d status %0d",
                   got.year_out, got.month_out, got.day_out, got.status);
            failures++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got.year_out !== want.year_out) begin
            $error("year_out mismatch: expected %0d, got %0d", want.year_out, got.year_out);
            failures++;
         end
         if (got.month_out !== want.month_out) begin
            $error("month_out mismatch: expected %0d, got %0d", want.month_out, got.month_out);
            failures++;
         end
         if (got.day_out !== want.day_out) begin
            $error("day_out mismatch: expected %0d, got %0d", want.day_out, got.day_out);
            failures++;
         end
         if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, got.status);
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   sender_idles   = 1'b1;
   bit   receiver_idles = 1'b1;

   gda_req_if req_bus ();
   gda_rsp_if rsp_bus ();

   date_scoreboard board = new();

   gregorian_date_advance #(
      .YEAR_BITS(gda_pkg::YEAR_FIELD_BITS),
      .DAYS_BITS(gda_pkg::DAYS_FIELD_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic gda_pkg::req_payload_type load_item(int unsigned y, int unsigned m,
                                                          int unsigned d);
      gda_pkg::req_payload_type it;
      it            = '0;
      it.operation  = gda_pkg::OP_LOAD;
      it.load_year  = gda_pkg::YEAR_FIELD_BITS'(y);
      it.load_month = 4'(m);
      it.load_day   = 5'(d);
      return it;
   endfunction

   function automatic gda_pkg::req_payload_type add_item(int unsigned n);
      gda_pkg::req_payload_type it;
      it           = '0;
      it.operation = gda_pkg::OP_ADD;
      it.add_days  = gda_pkg::DAYS_FIELD_BITS'(n);
      return it;
   endfunction

   // Most loads take a valid month and a day up to one past its end, with years
   // often near the leap and year-wrap corners; the rest keep fully random fields.
   function automatic gda_pkg::req_payload_type random_item();
      gda_pkg::req_payload_type it;
      int unsigned              pick, mlen;
      it.operation  = ($urandom_range(0, 99) < 45) ? gda_pkg::OP_ADD : gda_pkg::OP_LOAD;
      it.load_year  = gda_pkg::YEAR_FIELD_BITS'($urandom);
      it.load_month = 4'($urandom);
      it.load_day   = 5'($urandom);
      it.add_days   = gda_pkg::DAYS_FIELD_BITS'($urandom);
      if (it.operation == gda_pkg::OP_ADD) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            it.add_days = gda_pkg::DAYS_FIELD_BITS'($urandom_range(0, 62));
         end else if (pick < 85) begin
            it.add_days = gda_pkg::DAYS_FIELD_BITS'($urandom_range(0, 400));
         end
      end else if ($urandom_range(0, 99) < 78) begin
         pick = $urandom_range(0, 99);
         it.load_month = 4'($urandom_range(gda_pkg::MONTH_JAN, gda_pkg::MONTH_DEC));
         if (pick < 20) begin
            it.load_year = gda_pkg::YEAR_FIELD_BITS'(YEAR_MAX - $urandom_range(0, 2));
            if ($urandom_range(0, 1) == 1) begin
               it.load_month = gda_pkg::MONTH_DEC;
            end
         end else if (pick < 40) begin
            it.load_year = gda_pkg::YEAR_FIELD_BITS'(100 * $urandom_range(0, 655));
         end else if (pick < 50) begin
            it.load_year = gda_pkg::YEAR_FIELD_BITS'($urandom_range(0, 8));
         end
         mlen = date_scoreboard::days_in_month(it.load_year, it.load_month);
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            it.load_day = 5'(mlen);
         end else if (pick < 40) begin
            it.load_day = 5'(mlen + 1);
         end else begin
            it.load_day = 5'($urandom_range(1, mlen));
         end
      end
      return it;
   endfunction

   task automatic send_item(input gda_pkg::req_payload_type item);
      req_bus.valid   <= 1'b1;
      req_bus.payload <= item;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      board.note_request(item);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      int unsigned hold;
      rsp_bus.ready = 1'b1;
      forever begin
         @(posedge clock);
         if (receiver_idles && $urandom_range(0, 9) == 0) begin
            hold = $urandom_range(1, 16);
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         board.check_response(rsp_bus.payload);
      end
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("FAIL gregorian_date_advance");
      $finish;
   end

   initial begin
      gda_pkg::req_payload_type directed_q[$];
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;

      directed_q.push_back(add_item(0));
      directed_q.push_back(load_item(0, gda_pkg::MONTH_FEB, 29));
      directed_q.push_back(add_item(1));
      directed_q.push_back(load_item(1900, gda_pkg::MONTH_FEB, 29));
      directed_q.push_back(load_item(2000, gda_pkg::MONTH_FEB, 29));
      directed_q.push_back(load_item(2023, gda_pkg::MONTH_FEB, 29));
      directed_q.push_back(load_item(2024, gda_pkg::MONTH_FEB, 29));
      directed_q.push_back(load_item(2024, gda_pkg::MONTH_FEB, 30));
      directed_q.push_back(load_item(2024, 0, 10));
      directed_q.push_back(load_item(2024, 13, 10));
      directed_q.push_back(load_item(YEAR_MAX, 15, 31));
      directed_q.push_back(load_item(2024, gda_pkg::MONTH_JUN, 0));
      directed_q.push_back(load_item(2024, gda_pkg::MONTH_APR, 31));
      directed_q.push_back(load_item(2100, gda_pkg::MONTH_FEB, 28));
      directed_q.push_back(add_item(1));
      directed_q.push_back(load_item(YEAR_MAX, gda_pkg::MONTH_DEC, 31));
      directed_q.push_back(add_item(1));
      directed_q.push_back(load_item(YEAR_MAX, gda_pkg::MONTH_DEC, 31));
      directed_q.push_back(add_item(4095));
      directed_q.push_back(load_item(2024, gda_pkg::MONTH_JAN, 31));
      directed_q.push_back(add_item(4095));
      directed_q.push_back(load_item(1, gda_pkg::MONTH_JAN, 1));
      directed_q.push_back(add_item(365));
      directed_q.push_back(add_item(0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_q[i]) begin
         send_item(directed_q[i]);
      end
      wait_drained();

      for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - CALM_ITEMS) begin
            sender_idles   = 1'b0;
            receiver_idles = 1'b0;
         end
         if ($urandom_range(0, 99) == 0) begin
            wait_drained();
         end
         send_item(random_item());
      end
      wait_drained();
      repeat (SETTLE_TICKS) @(posedge clock);

      $display("Sent %0d loads (%0d rejected) and %0d adds (%0d wrapped past the top year).",
               board.loads, board.rejects, board.adds, board.wraps);
      $display("Checked %0d responses with %0d field mismatches.",
               board.checked, board.failures);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("PASS gregorian_date_advance");
      end else begin
         $display("FAIL gregorian_date_advance");
      end
      $finish;
   end

endmodule
